>>> design/sha1_pkg.sv
// sha1_pkg: shared types, constants and round helpers for the sha-1 digest block
// no dependencies
`default_nettype none
package sha1_pkg;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_SLOT = 6'd56;
    localparam logic [6:0]  LAST_ROUND = 7'd79;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam int QUEUE_DEPTH = 2;

    // item passed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_LEN, ST_OUT
    } back_state_t;

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (t < 7'd20)      round_f = (b & c) | (~b & d);
        else if (t < 7'd40) round_f = b ^ c ^ d;
        else if (t < 7'd60) round_f = (b & c) | (b & d) | (c & d);
        else                round_f = b ^ c ^ d;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        if (t < 7'd20)      round_k = K0;
        else if (t < 7'd40) round_k = K1;
        else if (t < 7'd60) round_k = K2;
        else                round_k = K3;
    endfunction
endpackage
`default_nettype wire

>>> design/sha1_front.sv
// sha1_front: input item acceptance, idle item filtering and a two-entry queue
// depends on sha1_pkg
`default_nettype none
module sha1_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire sha1_pkg::item_t s_item,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output sha1_pkg::item_t      q_item
);
    sha1_pkg::item_t mem_reg [sha1_pkg::QUEUE_DEPTH];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            push, pop, keep;

    // idle items (no byte, no end) are dropped here
    assign keep     = s_item.has_byte | s_item.end_of_message;
    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid & s_tready & keep;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid & q_ready;
    assign q_item   = mem_reg[rd_ptr_reg];

    // queue pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= s_item;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count lost a push");
endmodule
`default_nettype wire

>>> design/sha1_back.sv
// sha1_back: block assembly, padding, 80-round compression and digest output
// depends on sha1_pkg
`default_nettype none
module sha1_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire sha1_pkg::item_t q_item,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tlast
);
    sha1_pkg::back_state_t state_reg, state_next;
    logic [31:0] blk_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] len_reg;
    logic [6:0]  t_reg;
    logic        fin_reg;       // compression belongs to the final item
    logic        need_len_reg;  // a length block still follows
    logic        padded_reg;    // pad byte already placed for this message
    logic [2:0]  oidx_reg;
    logic        take;
    logic [31:0] w_x, w_cur, w_new, tmp;
    logic [3:0]  ti;

    assign take = q_valid & q_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha1_pkg::ST_IDLE: begin
                if (take) begin
                    if (q_item.has_byte && cnt_reg == 6'd63) state_next = sha1_pkg::ST_ROUND;
                    else if (q_item.end_of_message) state_next = sha1_pkg::ST_PAD;
                end
            end
            sha1_pkg::ST_ROUND: if (t_reg == sha1_pkg::LAST_ROUND) state_next = sha1_pkg::ST_FOLD;
            sha1_pkg::ST_FOLD: begin
                if (!fin_reg) state_next = sha1_pkg::ST_IDLE;
                else if (!padded_reg) state_next = sha1_pkg::ST_PAD;
                else if (need_len_reg) state_next = sha1_pkg::ST_LEN;
                else state_next = sha1_pkg::ST_OUT;
            end
            sha1_pkg::ST_PAD: state_next = sha1_pkg::ST_ROUND;
            sha1_pkg::ST_LEN: state_next = sha1_pkg::ST_ROUND;
            sha1_pkg::ST_OUT:
                if (m_tready && oidx_reg == 3'd4) state_next = sha1_pkg::ST_IDLE;
            default: state_next = sha1_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        q_ready  = (state_reg == sha1_pkg::ST_IDLE);
        m_tvalid = (state_reg == sha1_pkg::ST_OUT);
        m_tdata  = h_reg[oidx_reg];
        m_tlast  = (oidx_reg == 3'd4);
    end

    // schedule word and round sum
    assign ti    = t_reg[3:0];
    assign w_x   = blk_reg[ti+4'd13] ^ blk_reg[ti+4'd8] ^ blk_reg[ti+4'd2] ^ blk_reg[ti];
    assign w_new = {w_x[30:0], w_x[31]};
    assign w_cur = (t_reg < 7'd16) ? blk_reg[ti] : w_new;
    assign tmp   = {a_reg[26:0], a_reg[31:27]} + sha1_pkg::round_f(t_reg, b_reg, c_reg, d_reg)
                 + sha1_pkg::round_k(t_reg) + e_reg + w_cur;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha1_pkg::ST_IDLE;
            cnt_reg      <= 6'd0;
            len_reg      <= 64'd0;
            t_reg        <= 7'd0;
            fin_reg      <= 1'b0;
            need_len_reg <= 1'b0;
            padded_reg   <= 1'b0;
            oidx_reg     <= 3'd0;
        end else begin
            state_reg <= state_next;
            if (state_reg == sha1_pkg::ST_IDLE && take) begin
                if (q_item.has_byte) begin
                    cnt_reg <= cnt_reg + 6'd1;
                    len_reg <= len_reg + 64'd8;
                end
                fin_reg    <= q_item.end_of_message;
                padded_reg <= 1'b0;
            end
            if (state_reg == sha1_pkg::ST_PAD) begin
                need_len_reg <= (cnt_reg >= sha1_pkg::LEN_SLOT);
                padded_reg   <= 1'b1;
            end
            if (state_reg == sha1_pkg::ST_LEN) need_len_reg <= 1'b0;
            if (state_reg == sha1_pkg::ST_ROUND) t_reg <= t_reg + 7'd1;
            else t_reg <= 7'd0;
            if (state_reg == sha1_pkg::ST_OUT && m_tready) begin
                oidx_reg <= (oidx_reg == 3'd4) ? 3'd0 : oidx_reg + 3'd1;
                if (oidx_reg == 3'd4) begin
                    cnt_reg <= 6'd0;
                    len_reg <= 64'd0;
                end
            end
        end
    end

    // datapath: block, working words, chain value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) blk_reg[i] <= 32'd0;
            h_reg[0] <= sha1_pkg::H0; h_reg[1] <= sha1_pkg::H1; h_reg[2] <= sha1_pkg::H2;
            h_reg[3] <= sha1_pkg::H3; h_reg[4] <= sha1_pkg::H4;
        end else begin
            unique case (state_reg)
                sha1_pkg::ST_IDLE: begin
                    if (take && q_item.has_byte) begin
                        blk_reg[cnt_reg[5:2]] <= blk_reg[cnt_reg[5:2]] |
                            ({24'd0, q_item.data_byte} << {~cnt_reg[1:0], 3'b000});
                    end
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                end
                sha1_pkg::ST_PAD: begin
                    blk_reg[cnt_reg[5:2]] <= blk_reg[cnt_reg[5:2]] |
                        ({24'd0, sha1_pkg::PAD_BYTE} << {~cnt_reg[1:0], 3'b000});
                    if (cnt_reg < sha1_pkg::LEN_SLOT) begin
                        blk_reg[14] <= len_reg[63:32];
                        blk_reg[15] <= len_reg[31:0];
                    end
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                end
                sha1_pkg::ST_LEN: begin
                    blk_reg[14] <= len_reg[63:32];
                    blk_reg[15] <= len_reg[31:0];
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                end
                sha1_pkg::ST_ROUND: begin
                    if (t_reg >= 7'd16) blk_reg[ti] <= w_new;
                    e_reg <= d_reg; d_reg <= c_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    b_reg <= a_reg; a_reg <= tmp;
                end
                sha1_pkg::ST_FOLD: begin
                    h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    for (int i = 0; i < 16; i++) blk_reg[i] <= 32'd0;
                end
                sha1_pkg::ST_OUT: begin
                    if (m_tready && oidx_reg == 3'd4) begin
                        h_reg[0] <= sha1_pkg::H0; h_reg[1] <= sha1_pkg::H1;
                        h_reg[2] <= sha1_pkg::H2; h_reg[3] <= sha1_pkg::H3;
                        h_reg[4] <= sha1_pkg::H4;
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sha1_pkg::ST_ROUND && t_reg == sha1_pkg::LAST_ROUND)
        |=> state_reg == sha1_pkg::ST_FOLD) else $error("round count slip");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sha1_pkg::ST_ROUND) |=> t_reg == 7'd0) else $error("round counter stale");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(oidx_reg))
        else $error("digest word moved while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sha1_pkg::ST_OUT) |-> oidx_reg == 3'd0) else $error("output index stale");
endmodule
`default_nettype wire

>>> design/sha1_message_digest.sv
// sha1_message_digest: top level of the sha-1 digest block
// depends on sha1_pkg, sha1_front, sha1_back
//
// usage: the slave channel takes one item per handshake; s_tdata[7:0] is the
// message byte, s_tuser is has_byte, s_tlast marks the final item of a
// message. items with neither a byte nor tlast are dropped. a front queue of
// two items holds input while the back end compresses.
// the back end appends one byte per cycle while idle; the 64th byte of a block starts
// the 80-round compression, one round per cycle followed by a fold step. the
// final item adds a pad step (plus a length step when a second block is
// needed) and one or two compressions, then five digest words leave
// on the master channel, most significant first, m_tlast on the fifth.
// if the receiver stalls, the current word holds and the back end waits; the
// front queue still fills up to two items.
// reset (aresetn low, synchronous) loads the standard initial chaining value,
// clears the block, byte count and length, and empties the queue.
`default_nettype none
module sha1_message_digest (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tuser,   // has_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // digest_word[31:0]
    output logic             m_tlast
);
    sha1_pkg::item_t s_item, q_item;
    logic            q_valid, q_ready;

    assign s_item.data_byte      = s_tdata;
    assign s_item.has_byte       = s_tuser;
    assign s_item.end_of_message = s_tlast;

    sha1_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_item,
        .q_valid, .q_ready, .q_item
    );

    sha1_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast
    );
endmodule
`default_nettype wire

>>> test/sha1_digest_checker.sv
// sha1_digest_checker: watches both channels of sha1_message_digest, predicts digests
// depends on nothing but the port-level behavior of the block
module sha1_digest_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               words_pending
);
    localparam logic [31:0] IV [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                       32'h10325476, 32'hC3D2E1F0};

    typedef struct {
        logic [31:0] word;
        logic        last;
    } digest_word_t;

    logic [31:0] chain [5];
    logic [31:0] blk [16];
    logic [5:0]  byte_pos;
    logic [63:0] bit_len;
    digest_word_t digest_q [$];

    assign words_pending = digest_q.size();

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        rol = (x << n) | (x >> (32 - n));
    endfunction

    // one 80-round compression of blk into chain, then clear blk
    task automatic compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, w_t, tmp;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                w_t = w[t];
            end else begin
                w_t = rol(w[(t - 3) & 15] ^ w[(t - 8) & 15] ^ w[(t - 14) & 15] ^ w[t & 15], 1);
                w[t & 15] = w_t;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (t < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            tmp = rol(a, 5) + f + k + e + w_t;
            e = d; d = c; c = rol(b, 30); b = a; a = tmp;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        for (int i = 0; i < 16; i++) blk[i] = '0;
    endtask

    task automatic put_byte(input logic [7:0] v);
        blk[byte_pos[5:2]] |= 32'(v) << ((3 - byte_pos[1:0]) * 8);
    endtask

    task automatic restart();
        for (int i = 0; i < 5; i++) chain[i] = IV[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        byte_pos = '0;
        bit_len = '0;
    endtask

    // absorb one accepted item, queue the digest on the final one
    task automatic absorb(input logic [7:0] v, input logic has, input logic fin);
        digest_word_t dw;
        if (has) begin
            put_byte(v);
            bit_len += 64'd8;
            byte_pos += 6'd1;
            if (byte_pos == 6'd0) compress();
        end
        if (fin) begin
            put_byte(8'h80);
            if (byte_pos >= 6'd56) compress();
            blk[14] = bit_len[63:32];
            blk[15] = bit_len[31:0];
            compress();
            for (int i = 0; i < 5; i++) begin
                dw.word = chain[i];
                dw.last = (i == 4);
                digest_q.push_back(dw);
            end
            restart();
        end
    endtask

    task automatic report(input string what);
        $display("error at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        digest_word_t exp_w;
        if (!aresetn) begin
            restart();
            digest_q.delete();
        end else begin
            // compare outputs before absorbing, a new item cannot produce same-edge words
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    report($sformatf("unexpected digest word %h", m_tdata));
                end else begin
                    exp_w = digest_q.pop_front();
                    if (m_tdata !== exp_w.word)
                        report($sformatf("digest word %h, expected %h", m_tdata, exp_w.word));
                    if (m_tlast !== exp_w.last)
                        report($sformatf("tlast %b, expected %b", m_tlast, exp_w.last));
                end
            end
            if (s_tvalid && s_tready) absorb(s_tdata, s_tuser, s_tlast);
        end
    end
endmodule

>>> test/tb.sv
// tb: stimulus and verdict for sha1_message_digest
// depends on sha1_message_digest (with sha1_pkg) and sha1_digest_checker
module tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // data_byte[7:0]
    logic        s_tuser = 1'b0; // has_byte
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // digest_word[31:0]
    logic        m_tlast;
    int          fail_count;
    int          words_pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    sha1_message_digest DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    sha1_digest_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .words_pending(words_pending)
    );

    // receiver: random stalls, plus a counted long hold-off on request
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one item, with random idle cycles in front, and wait for acceptance
    task automatic send_item(input logic [7:0] v, input logic has, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= has;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_message(input int n_bytes, input logic empty_end);
        for (int i = 0; i < n_bytes; i++) begin
            // occasional idle item inside the message
            if ($urandom_range(15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, !empty_end && i == n_bytes - 1);
        end
        if (empty_end || n_bytes == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (words_pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty message, extreme bytes, idle items
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);
        drain();

        // long receiver hold-off while messages keep coming: a message past the
        // length slot, then a full block ending on its last byte
        hold_off <= 400;
        send_message(57, 1'b0);
        send_message(64, 1'b0);
        drain();

        // random messages of at most three bytes over three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 51 : 0;
            recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 23 : 0;
            for (int m = 0; m < 2; m++) begin
                send_message($urandom_range(3), 1'($urandom_range(1)));
            end
        end
        drain();
        repeat (300) @(posedge aclk);
        if (fail_count == 0 && words_pending == 0) begin
            $display("sha1_message_digest: match");
        end else begin
            $display("sha1_message_digest: mismatch");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("sha1_message_digest: mismatch");
        $finish;
    end
endmodule

>>> files.f
design/sha1_pkg.sv
design/sha1_front.sv
design/sha1_back.sv
design/sha1_message_digest.sv
test/sha1_digest_checker.sv
test/tb.sv
